// File: sv/dkt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkt_pkg: shared types and constants for the key table
// Word formats, result codes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package dkt_pkg;

	// table geometry
	localparam int POOL_DEPTH = 128;
	localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

	// largest signed 64-bit value, rejected as a generation
	localparam logic [63:0] GEN_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// result codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BADGEN   = 3'd1;
	localparam logic [2:0] ST_NOTOWNED = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_DUP      = 3'd4;
	localparam logic [2:0] ST_MISSING  = 3'd5;

	// request word
	typedef struct packed {
		logic               operation;
		logic [63:0]        key_high;
		logic [63:0]        key_mid;
		logic [31:0]        key_low;
		logic signed [63:0] generation_in;
		logic               key_owned;
	} req_t;

	// response word
	typedef struct packed {
		logic        accepted;
		logic [2:0]  status;
		logic [7:0]  entry_count;
		logic [62:0] next_index;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;      // capture request word
		logic       scan_clr;  // restart scan pointer
		logic       scan_rd;   // read entry at scan pointer, advance
		logic       last_rd;   // read last live entry
		logic       hole_ld;   // remember index of the hit
		logic       append;    // store new entry at the tail
		logic       move;      // last entry into the hole, shrink
		logic       res_ld;    // load response register
		logic [2:0] res_code;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_remove;
		logic bad_gen;
		logic not_owned;
		logic full;
		logic empty;
		logic more;      // scan pointer still below count
		logic match;     // compared entry hits
		logic last_cmp;  // compared entry was the last live one
	} sts_t;

endpackage

// File: sv/dedup_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_key_table: bounded key/generation table with insert and remove
// Insert checks generation, ownership, room and duplicates, then appends.
// Remove looks up the key and fills the hole with the last entry.
// ----------------------------------------------------------------------------
//
//   channel  signals                     word    direction
//   req      req_valid req_stall req     req_t   into the block
//   rsp      rsp_valid rsp_stall rsp     rsp_t   out of the block
//
// One word at a time. An insert that passes the prechecks, and a remove on a
// table that is not empty, walk the live entries in a linear scan of the
// entry memory through its single registered read port, one entry each
// cycle; an insert into an empty table appends without a scan. Early rejects
// (bad generation, not owned, full) and a remove on an empty table skip the
// scan as well.
// Reset clears count and next index; the entry memory needs no clearing pass.
// A stalled response holds; the next request is taken once it is loaded.
// ----------------------------------------------------------------------------
module dedup_key_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dkt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dkt_pkg::rsp_t rsp
);

	dkt_pkg::cmd_t cmd;
	dkt_pkg::sts_t sts;

	dkt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dkt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

// File: sv/dkt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkt_datapath: entry memory, counters and comparators
// Holds the captured request, the key/generation memory with one registered
// read port, the entry count, the next-index tracker and the response word.
// ----------------------------------------------------------------------------
module dkt_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  dkt_pkg::req_t req,
	input  dkt_pkg::cmd_t cmd,
	output dkt_pkg::sts_t sts,
	output dkt_pkg::rsp_t rsp
);

	typedef struct packed {
		logic [159:0] key;
		logic [62:0]  gen;
	} entry_t;

	// captured request
	logic                       op_q;
	logic [159:0]               key_q;
	logic [63:0]                gen_q;
	logic                       owned_q;

	logic [dkt_pkg::CNT_W-1:0]  count_q;
	logic [62:0]                next_q;
	logic [dkt_pkg::CNT_W-1:0]  idx_q;
	logic                       issue_s1;
	logic [dkt_pkg::IDX_W-1:0]  idx_s1;
	logic [dkt_pkg::IDX_W-1:0]  hole_q;
	entry_t                     rdata_s1;
	dkt_pkg::rsp_t              rsp_q;

	entry_t                     mem [dkt_pkg::POOL_DEPTH];

	logic [dkt_pkg::CNT_W-1:0]  cnt_m1;
	logic [dkt_pkg::IDX_W-1:0]  rd_addr;
	logic                       we;
	logic [dkt_pkg::IDX_W-1:0]  wr_addr;
	entry_t                     wr_data;
	logic                       key_eq;
	logic                       gen_eq;
	logic [dkt_pkg::CNT_W+7:0]  count_ext;

	assign cnt_m1 = count_q - dkt_pkg::CNT_W'(1);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= req.operation;
			key_q   <= {req.key_high, req.key_mid, req.key_low};
			gen_q   <= req.generation_in;
			owned_q <= req.key_owned;
		end
	end

	// memory ports
	assign rd_addr = cmd.last_rd ? cnt_m1[dkt_pkg::IDX_W-1:0] : idx_q[dkt_pkg::IDX_W-1:0];
	assign we      = cmd.append | cmd.move;
	assign wr_addr = cmd.move ? hole_q : count_q[dkt_pkg::IDX_W-1:0];
	assign wr_data = cmd.move ? rdata_s1 : entry_t'{key: key_q, gen: gen_q[62:0]};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// counters and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			next_q   <= '0;
			idx_q    <= '0;
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= cmd.scan_rd;
			if (cmd.scan_clr) begin
				idx_q <= '0;
			end else if (cmd.scan_rd) begin
				idx_q <= idx_q + dkt_pkg::CNT_W'(1);
			end
			if (cmd.append) begin
				count_q <= count_q + dkt_pkg::CNT_W'(1);
				if (next_q <= gen_q[62:0]) begin
					next_q <= gen_q[62:0] + 63'd1;
				end
			end else if (cmd.move) begin
				count_q <= cnt_m1;
			end
		end
	end

	// index tags, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			idx_s1 <= idx_q[dkt_pkg::IDX_W-1:0];
		end
		if (cmd.hole_ld) begin
			hole_q <= idx_s1;
		end
	end

	// comparators
	assign key_eq = (rdata_s1.key == key_q);
	assign gen_eq = (rdata_s1.gen == gen_q[62:0]);

	always_comb begin
		sts.is_remove = (op_q == dkt_pkg::OP_REMOVE);
		sts.bad_gen   = gen_q[63] | (gen_q == dkt_pkg::GEN_TOP);
		sts.not_owned = ~owned_q;
		sts.full      = (count_q >= dkt_pkg::CNT_W'(dkt_pkg::POOL_DEPTH));
		sts.empty     = (count_q == '0);
		sts.more      = (idx_q < count_q);
		sts.match     = issue_s1 & (key_eq | ((op_q == dkt_pkg::OP_INSERT) & gen_eq));
		sts.last_cmp  = issue_s1 & ((dkt_pkg::CNT_W'(idx_s1) + dkt_pkg::CNT_W'(1)) == count_q);
	end

	// response word
	assign count_ext = {8'd0, count_q};

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			rsp_q.accepted    <= (cmd.res_code == dkt_pkg::ST_OK);
			rsp_q.status      <= cmd.res_code;
			rsp_q.entry_count <= count_ext[7:0];
			rsp_q.next_index  <= next_q;
		end
	end

	assign rsp = rsp_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dkt_pkg::CNT_W'(dkt_pkg::POOL_DEPTH))
		else $error("entry count above pool depth");

endmodule

// File: sv/dkt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkt_ctrl: sequencing for insert and remove
// Runs the precheck, the linear scan, the append or hole fill, and hands the
// result to the response register.
// ----------------------------------------------------------------------------
module dkt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  dkt_pkg::sts_t sts,
	output dkt_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_APPEND = 3'd3;
	localparam logic [2:0] S_MVRD   = 3'd4;
	localparam logic [2:0] S_MVWR   = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] code_q, code_d;
	logic       rsp_valid_q;
	logic       rsp_free;

	assign rsp_free  = ~rsp_valid_q | ~rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// next state and commands
	always_comb begin
		cmd          = '0;
		cmd.res_code = code_q;
		state_d      = state_q;
		code_d       = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.is_remove) begin
					if (sts.empty) begin
						code_d  = dkt_pkg::ST_MISSING;
						state_d = S_FIN;
					end else begin
						cmd.scan_clr = 1'b1;
						state_d      = S_SCAN;
					end
				end else begin
					priority if (sts.bad_gen) begin
						code_d  = dkt_pkg::ST_BADGEN;
						state_d = S_FIN;
					end else if (sts.not_owned) begin
						code_d  = dkt_pkg::ST_NOTOWNED;
						state_d = S_FIN;
					end else if (sts.full) begin
						code_d  = dkt_pkg::ST_FULL;
						state_d = S_FIN;
					end else if (sts.empty) begin
						state_d = S_APPEND;
					end else begin
						cmd.scan_clr = 1'b1;
						state_d      = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_rd = sts.more & ~sts.match;
				if (sts.match) begin
					if (sts.is_remove) begin
						cmd.hole_ld = 1'b1;
						state_d     = S_MVRD;
					end else begin
						code_d  = dkt_pkg::ST_DUP;
						state_d = S_FIN;
					end
				end else if (sts.last_cmp) begin
					if (sts.is_remove) begin
						code_d  = dkt_pkg::ST_MISSING;
						state_d = S_FIN;
					end else begin
						state_d = S_APPEND;
					end
				end
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				code_d     = dkt_pkg::ST_OK;
				state_d    = S_FIN;
			end
			S_MVRD: begin
				cmd.last_rd = 1'b1;
				state_d     = S_MVWR;
			end
			S_MVWR: begin
				cmd.move = 1'b1;
				code_d   = dkt_pkg::ST_OK;
				state_d  = S_FIN;
			end
			S_FIN: begin
				if (rsp_free) begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, code and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= dkt_pkg::ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (cmd.res_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (~rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("response raised outside finish state");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> (~sts.full && ~sts.is_remove))
		else $error("append into full table or on remove");

	a_move_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> (~sts.empty && sts.is_remove))
		else $error("hole fill with no live entry");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> sts.more)
		else $error("scan read beyond count");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> req_stall)
		else $error("second word taken while busy");

endmodule
